// ----- rtl/sta_pkg.sv -----
// Package for the sparse triplet add/transpose block.
// Shared field widths, controller states and the command/status structs.
// No dependencies.
package sta_pkg;

  // Fixed widths of the transaction fields
  localparam int VAL_W = 16;
  localparam int SUM_W = 17;
  localparam int IDX_W = 2;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // write the incoming element, advance the load count
    logic clear;  // reset scan counters and the held entry
    logic scan;   // read one position, advance the scan counters
    logic flush;  // emit the held entry as last, or the empty marker
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic load_last;  // next element completes matrix B
    logic scan_last;  // final position of the transposed scan is being read
  } status_t;

endpackage

// ----- rtl/sta_ram.sv -----
// Generic single-port RAM with registered read data.
// Standalone; used for both matrix stores.
module sta_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register the read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/sta_ctrl.sv -----
// Controller state machine for the sparse triplet add/transpose block.
// Depends on sta_pkg for the state type and command/status structs.
module sta_ctrl
  import sta_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t stat,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state;
  state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (start && stat.load_last) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_FLUSH;
      ST_FLUSH: state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // Commands and busy
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_LOAD: begin
        busy      = 1'b0;
        cmd.load  = start;
        cmd.clear = start && stat.load_last;
      end
      ST_SCAN:  cmd.scan  = 1'b1;
      ST_DRAIN: cmd       = '0;
      ST_FLUSH: cmd.flush = 1'b1;
      default:  cmd       = '0;
    endcase
  end

endmodule

// ----- rtl/sta_datapath.sv -----
// Datapath: matrix stores, load counter, scan counters and result registers.
// Depends on sta_pkg and sta_ram.
module sta_datapath
  import sta_pkg::*;
#(
  parameter int DIM = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output status_t                 stat,
  input  logic signed [VAL_W-1:0] element_value,
  output logic                    result_valid,
  output logic                    list_phase,
  output logic [IDX_W-1:0]        row_index,
  output logic [IDX_W-1:0]        col_index,
  output logic signed [SUM_W-1:0] entry_value,
  output logic                    last_of_run,
  output logic                    empty_marker
);

  localparam int CELLS  = DIM * DIM;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int LCNT_W = $clog2(2 * CELLS);

  logic [LCNT_W-1:0] load_count;
  logic              load_to_a;
  logic [ADDR_W-1:0] load_addr;
  logic [ADDR_W-1:0] scan_addr;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [VAL_W-1:0]  rd_a;
  logic [VAL_W-1:0]  rd_b;

  logic              scan_phase;
  logic [IDX_W-1:0]  outer;
  logic [IDX_W-1:0]  inner;
  logic              inner_end;
  logic              outer_end;

  logic              s1_valid;
  logic              s1_phase;
  logic [IDX_W-1:0]  s1_row;
  logic [IDX_W-1:0]  s1_col;
  logic              s1_nz;
  logic signed [SUM_W-1:0] s1_sum;

  logic              pend_valid;
  logic              pend_phase;
  logic [IDX_W-1:0]  pend_row;
  logic [IDX_W-1:0]  pend_col;
  logic signed [SUM_W-1:0] pend_sum;

  // Load addressing: first CELLS elements go to A, the rest to B
  assign load_to_a = (load_count < LCNT_W'(CELLS));
  assign load_addr = load_to_a ? ADDR_W'(load_count)
                               : ADDR_W'(load_count - LCNT_W'(CELLS));

  // Scan addressing: row-major for the sum list, column-major for the transpose
  assign scan_addr = scan_phase ? ADDR_W'(ADDR_W'(inner) * ADDR_W'(DIM) + ADDR_W'(outer))
                                : ADDR_W'(ADDR_W'(outer) * ADDR_W'(DIM) + ADDR_W'(inner));
  assign addr_a = cmd.load ? load_addr : scan_addr;
  assign addr_b = addr_a;

  sta_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_ram_a (
    .clk   (clk),
    .we    (cmd.load && load_to_a),
    .addr  (addr_a),
    .wdata (element_value),
    .rdata (rd_a)
  );

  sta_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_ram_b (
    .clk   (clk),
    .we    (cmd.load && !load_to_a),
    .addr  (addr_b),
    .wdata (element_value),
    .rdata (rd_b)
  );

  // Status toward the controller
  assign inner_end      = (inner == IDX_W'(DIM - 1));
  assign outer_end      = (outer == IDX_W'(DIM - 1));
  assign stat.load_last = (load_count == LCNT_W'(2 * CELLS - 1));
  assign stat.scan_last = scan_phase && outer_end && inner_end;

  // Advance the load count, wrap after B completes
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (cmd.load) begin
      if (stat.load_last) load_count <= '0;
      else                load_count <= load_count + 1'b1;
    end
  end

  // Advance the scan counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      scan_phase <= 1'b0;
      outer      <= '0;
      inner      <= '0;
    end else if (cmd.scan) begin
      if (inner_end) begin
        inner <= '0;
        if (outer_end) begin
          outer      <= '0;
          scan_phase <= 1'b1;
        end else begin
          outer <= outer + 1'b1;
        end
      end else begin
        inner <= inner + 1'b1;
      end
    end
  end

  // Tag that travels with the registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.scan;
    end
    s1_phase <= scan_phase;
    s1_row   <= outer;
    s1_col   <= inner;
  end

  // Nonzero test and full-width sum
  assign s1_nz  = (rd_a != '0) || (rd_b != '0);
  assign s1_sum = SUM_W'($signed(rd_a)) + SUM_W'($signed(rd_b));

  // Hold one found entry so the final one can be flagged as last
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      pend_valid <= 1'b0;
    end else if (s1_valid && s1_nz) begin
      pend_valid <= 1'b1;
    end
    if (s1_valid && s1_nz) begin
      pend_phase <= s1_phase;
      pend_row   <= s1_row;
      pend_col   <= s1_col;
      pend_sum   <= s1_sum;
    end
  end

  // Result registers: release the held entry when a newer one arrives,
  // and on flush emit it as last or emit the empty marker
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (s1_valid && s1_nz && pend_valid) || cmd.flush;
    end
    priority if (cmd.flush && !pend_valid) begin
      list_phase   <= 1'b0;
      row_index    <= '0;
      col_index    <= '0;
      entry_value  <= '0;
      last_of_run  <= 1'b1;
      empty_marker <= 1'b1;
    end else begin
      list_phase   <= pend_phase;
      row_index    <= pend_row;
      col_index    <= pend_col;
      entry_value  <= pend_sum;
      last_of_run  <= cmd.flush;
      empty_marker <= 1'b0;
    end
  end

endmodule

// ----- rtl/sparse_triplet_add_transpose.sv -----
// Sparse triplet addition with transpose: loads two DIM x DIM signed matrices
// (A then B, row-major, one element per start while busy is low). The element
// that completes B starts a scan, with busy high, in which the sum triplet
// list and then the transposed list come out, one result per result_valid
// cycle, in order. The scan rate is set by the single read port of each matrix
// RAM, one position per cycle. The receiver cannot stall: take each result on
// the cycle result_valid is high. An all-zero pair yields one empty_marker result.
// Depends on sta_pkg, sta_ctrl, sta_datapath.
module sparse_triplet_add_transpose
  import sta_pkg::*;
#(
  parameter int DIM = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] element_value,
  output logic                    result_valid,
  output logic                    list_phase,
  output logic [IDX_W-1:0]        row_index,
  output logic [IDX_W-1:0]        col_index,
  output logic signed [SUM_W-1:0] entry_value,
  output logic                    last_of_run,
  output logic                    empty_marker
);

  cmd_t    cmd;
  status_t stat;

  sta_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sta_datapath #(.DIM(DIM)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .element_value (element_value),
    .result_valid  (result_valid),
    .list_phase    (list_phase),
    .row_index     (row_index),
    .col_index     (col_index),
    .entry_value   (entry_value),
    .last_of_run   (last_of_run),
    .empty_marker  (empty_marker)
  );

endmodule

// ----- test/tb.sv -----
// Testbench for sparse_triplet_add_transpose: loads matrix pairs (A then B), predicts
// the sum triplet list and its transpose for each pair, and checks every result.
// Depends on sta_pkg and the sparse_triplet_add_transpose RTL.
`timescale 1ns / 100ps

module tb
  import sta_pkg::*;
();

  localparam int DIM        = 4;
  localparam int CELLS      = DIM * DIM;
  localparam int DRAIN_WAIT = 2 * CELLS + 8;
  localparam int CYCLE_CAP  = 100000;
  localparam int IDLE_PCT   = 18;

  typedef logic signed [VAL_W-1:0] matrix_t [CELLS];

  typedef struct {
    logic                    phase;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] value;
    logic                    last;
    logic                    empty;
  } triplet_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic signed [VAL_W-1:0] element_value;
  logic                    result_valid;
  logic                    list_phase;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [SUM_W-1:0] entry_value;
  logic                    last_of_run;
  logic                    empty_marker;

  // Predictor state: both matrices and the running load position
  logic signed [VAL_W-1:0] a_cells [CELLS];
  logic signed [VAL_W-1:0] b_cells [CELLS];
  int                      load_pos;

  triplet_t expected_triplets[$];
  triplet_t next_triplet;
  int       error_count = 0;
  int       cycle_count = 0;
  int       idle_pct;

  sparse_triplet_add_transpose #(
    .DIM(DIM)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .element_value(element_value),
    .result_valid (result_valid),
    .list_phase   (list_phase),
    .row_index    (row_index),
    .col_index    (col_index),
    .entry_value  (entry_value),
    .last_of_run  (last_of_run),
    .empty_marker (empty_marker)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Queue the triplet lists that a completed pair produces
  function automatic void push_triplet(logic phase, int r, int c, logic signed [SUM_W-1:0] v,
                                       logic empty);
    triplet_t t;
    t.phase = phase;
    t.row   = IDX_W'(r);
    t.col   = IDX_W'(c);
    t.value = v;
    t.last  = empty;
    t.empty = empty;
    expected_triplets.push_back(t);
  endfunction

  function automatic void predict_triplet_lists();
    int                      idx;
    int                      entries;
    logic signed [SUM_W-1:0] sum;
    entries = 0;
    // Sum list in row-major order
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        idx = r * DIM + c;
        if (a_cells[idx] != 0 || b_cells[idx] != 0) begin
          sum = a_cells[idx] + b_cells[idx];
          push_triplet(1'b0, r, c, sum, 1'b0);
          entries++;
        end
      end
    end
    if (entries == 0) begin
      push_triplet(1'b0, 0, 0, '0, 1'b1);
      return;
    end
    // Transposed list: walk columns first, swap row and column
    for (int c = 0; c < DIM; c++) begin
      for (int r = 0; r < DIM; r++) begin
        idx = r * DIM + c;
        if (a_cells[idx] != 0 || b_cells[idx] != 0) begin
          sum = a_cells[idx] + b_cells[idx];
          push_triplet(1'b1, c, r, sum, 1'b0);
        end
      end
    end
    expected_triplets[expected_triplets.size() - 1].last = 1'b1;
  endfunction

  function automatic void predict_load(logic signed [VAL_W-1:0] v);
    if (load_pos < CELLS) a_cells[load_pos] = v;
    else b_cells[load_pos - CELLS] = v;
    load_pos++;
    if (load_pos == 2 * CELLS) begin
      load_pos = 0;
      predict_triplet_lists();
    end
  endfunction

  // Send one element: random idle cycles, then hold start until accepted
  task automatic send_element(input logic signed [VAL_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start         = 1'b0;
      element_value = VAL_W'($urandom);
    end
    @(negedge clk);
    start         = 1'b1;
    element_value = v;
    do @(posedge clk); while (busy !== 1'b0);
    predict_load(v);
  endtask

  task automatic send_pair(input matrix_t a_vals, input matrix_t b_vals);
    for (int i = 0; i < CELLS; i++) send_element(a_vals[i]);
    for (int i = 0; i < CELLS; i++) send_element(b_vals[i]);
  endtask

  // Pause the sender until every expected transaction has arrived
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (expected_triplets.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string fname, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      error_count++;
    end
  endtask

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      if (expected_triplets.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual row %0d col %0d value %0d",
                 $time, row_index, col_index, entry_value);
        error_count++;
      end else begin
        next_triplet = expected_triplets.pop_front();
        check_field("list_phase", 32'(next_triplet.phase), 32'(list_phase));
        check_field("row_index", 32'(next_triplet.row), 32'(row_index));
        check_field("col_index", 32'(next_triplet.col), 32'(col_index));
        check_field("entry_value", 32'(next_triplet.value), 32'(entry_value));
        check_field("last_of_run", 32'(next_triplet.last), 32'(last_of_run));
        check_field("empty_marker", 32'(next_triplet.empty), 32'(empty_marker));
      end
    end else if (!rst && result_valid !== 1'b0) begin
      $display("%0t: result_valid unknown: expected 0 or 1, actual %b", $time, result_valid);
      error_count++;
    end
  end

  // Both matrices all zero: one empty-list marker
  task automatic test_empty_pair();
    matrix_t zeros;
    foreach (zeros[i]) zeros[i] = '0;
    send_pair(zeros, zeros);
  endtask

  // Extreme sums, cancellation to zero, entries in only one matrix, alternating bits
  task automatic test_extreme_values();
    matrix_t a_vals;
    matrix_t b_vals;
    foreach (a_vals[i]) begin
      a_vals[i] = '0;
      b_vals[i] = '0;
    end
    a_vals[0]  = 16'sh7FFF; b_vals[0]  = 16'sh7FFF;
    a_vals[1]  = -16'sh8000; b_vals[1] = -16'sh8000;
    a_vals[2]  = 16'sd5;    b_vals[2]  = -16'sd5;
    b_vals[3]  = 16'sd7;
    a_vals[6]  = 16'sh5555; b_vals[6]  = 16'shAAAA;
    a_vals[9]  = 16'shAAAA; b_vals[9]  = 16'sh7FFF;
    a_vals[12] = 16'sh7FFF; b_vals[12] = -16'sh8000;
    a_vals[15] = -16'sd1;
    send_pair(a_vals, b_vals);
  endtask

  // A single entry in the far corner: one triplet in each list
  task automatic test_corner_entry();
    matrix_t a_vals;
    matrix_t b_vals;
    foreach (a_vals[i]) begin
      a_vals[i] = '0;
      b_vals[i] = '0;
    end
    b_vals[CELLS-1] = -16'sd300;
    send_pair(a_vals, b_vals);
  endtask

  function automatic logic signed [VAL_W-1:0] random_element();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: return 16'sh7FFF;
          1: return -16'sh8000;
          2: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Random pairs of varying density, with cancelling sums now and then
  task automatic test_random_pairs(input int pair_total);
    matrix_t a_vals;
    matrix_t b_vals;
    int      density;
    for (int p = 0; p < pair_total; p++) begin
      case ($urandom_range(5))
        0: density = 0;
        1: density = 10;
        2: density = 30;
        3: density = 60;
        default: density = 100;
      endcase
      foreach (a_vals[i]) begin
        a_vals[i] = ($urandom_range(99) < density) ? random_element() : '0;
        b_vals[i] = ($urandom_range(99) < density) ? random_element() : '0;
        if (a_vals[i] != 0 && $urandom_range(7) == 0) b_vals[i] = -a_vals[i];
      end
      // Hold a stretch with no idling at all
      idle_pct = (p == 2 || p == 3) ? 0 : IDLE_PCT;
      send_pair(a_vals, b_vals);
      if (p == 4) wait_drained();
    end
    idle_pct = IDLE_PCT;
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    element_value = '0;
    load_pos      = 0;
    idle_pct      = IDLE_PCT;
    foreach (a_cells[i]) begin
      a_cells[i] = '0;
      b_cells[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_pair();
    test_extreme_values();
    test_corner_entry();
    test_random_pairs(5);

    // Drain, then allow the scan latency to pass
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
